@@ sv/rws_pkg.sv @@
package rws_pkg;

  // Fixed field widths of the block's interface.
  localparam int KIND_BITS  = 2;
  localparam int INDEX_BITS = 6;
  localparam int RAND_BITS  = 16;
  localparam int TOTAL_BITS = 22;
  localparam int CFG_BITS   = 7;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = '1;
  localparam logic [CFG_BITS-1:0]   CFG_RESET   = 7'd64;

  // Item kinds. The fourth code carries no meaning and is dropped.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_TOTAL  = 2'd1,
    KIND_SELECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_SELECT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;      // store the fitness of the accepted write item
    logic load;    // clear the walk and capture the selection target
    logic step;    // walk one more entry
    logic sat;     // walk is a total pass: saturate the sum
    logic commit;  // store the finished sum as the running total
    logic emit;    // present a selection result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the entry now in the adder reaches the slice
    logic walk_end;  // all entries in use have been read and added
  } status_t;

endpackage

@@ sv/rws_ram.sv @@
module rws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rws_ctrl.sv @@
module rws_ctrl import rws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KIND_BITS-1:0] in_kind,
  input  status_t              status_i,
  output cmd_t                 cmd_o,
  output logic                 busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_t'(in_kind))
            KIND_WRITE: begin
              cmd_o.wr = 1'b1;
            end
            KIND_TOTAL: begin
              cmd_o.load = 1'b1;
              state_nxt  = ST_TOTAL;
            end
            KIND_SELECT: begin
              cmd_o.load = 1'b1;
              state_nxt  = ST_SELECT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TOTAL: begin
        cmd_o.step = 1'b1;
        cmd_o.sat  = 1'b1;
        if (status_i.walk_end) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SELECT: begin
        cmd_o.step = 1'b1;
        if (status_i.hit || status_i.walk_end) begin
          cmd_o.emit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ sv/rws_datapath.sv @@
module rws_datapath import rws_pkg::*; #(
  parameter int ENTRIES      = 64,
  parameter int FITNESS_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [INDEX_BITS-1:0]   in_entry_index,
  input  logic [FITNESS_BITS-1:0] in_fitness_value,
  input  logic [RAND_BITS-1:0]    in_random_fraction,
  input  logic                    cfg_we,
  input  logic [CFG_BITS-1:0]     cfg_genomes_in_use,
  output logic                    out_valid,
  output logic [INDEX_BITS-1:0]   out_chosen_index,
  output logic                    out_found,
  output logic [TOTAL_BITS-1:0]   out_total_fitness
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ACC_W  = (FITNESS_BITS + IDX_W > TOTAL_BITS) ? FITNESS_BITS + IDX_W
                                                              : TOTAL_BITS;
  localparam int CMP_W  = ACC_W + RAND_BITS;
  localparam int PROD_W = RAND_BITS + TOTAL_BITS;

  logic [CFG_BITS-1:0]     gin_r;
  logic [TOTAL_BITS-1:0]   total_r;
  logic [PROD_W-1:0]       target_r;
  logic [ACC_W-1:0]        accum_r;
  logic [ACC_W-1:0]        accum_nxt;
  logic [CNT_W-1:0]        rd_cnt_r;
  logic                    dv_r;
  logic [IDX_W-1:0]        di_r;
  logic                    out_valid_r;
  logic [INDEX_BITS-1:0]   chosen_r;
  logic                    found_r;
  logic [TOTAL_BITS-1:0]   total_out_r;

  logic [CNT_W-1:0]        active_cnt;
  logic                    issue;
  logic                    ram_we;
  logic [FITNESS_BITS-1:0] rdata;
  logic [ACC_W:0]          sum_ext;
  logic [PROD_W-1:0]       product;
  logic                    hit;

  // A count above the table size acts as the table size.
  always_comb begin
    if (32'(gin_r) > 32'(ENTRIES)) begin
      active_cnt = CNT_W'(ENTRIES);
    end else begin
      active_cnt = CNT_W'(gin_r);
    end
  end

  assign ram_we = cmd_i.wr && (32'(in_entry_index) < 32'(ENTRIES));
  assign issue  = cmd_i.step && (rd_cnt_r < active_cnt);

  rws_ram #(
    .WIDTH (FITNESS_BITS),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (in_fitness_value),
    .re    (issue),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign product = PROD_W'(in_random_fraction) * PROD_W'(total_r);

  // Total passes saturate; selection walks keep the exact sum.
  assign sum_ext = {1'b0, accum_r} + (ACC_W + 1)'(rdata);

  always_comb begin
    if (cmd_i.sat && (sum_ext > (ACC_W + 1)'(TOTAL_MAX))) begin
      accum_nxt = ACC_W'(TOTAL_MAX);
    end else begin
      accum_nxt = sum_ext[ACC_W-1:0];
    end
  end

  assign hit = dv_r && ({accum_nxt, {RAND_BITS{1'b0}}} >= CMP_W'(target_r));

  assign status_o.hit      = hit;
  assign status_o.walk_end = !dv_r && (rd_cnt_r == active_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gin_r       <= CFG_RESET;
      total_r     <= '0;
      rd_cnt_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gin_r <= cfg_genomes_in_use;
      end
      if (cmd_i.commit) begin
        total_r <= accum_r[TOTAL_BITS-1:0];
      end
      if (cmd_i.load) begin
        rd_cnt_r <= '0;
        dv_r     <= 1'b0;
      end else if (cmd_i.step) begin
        if (issue) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
        dv_r <= issue;
      end
      out_valid_r <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      accum_r  <= '0;
      target_r <= product;
    end else if (cmd_i.step && dv_r) begin
      accum_r <= accum_nxt;
    end
    if (issue) begin
      di_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (cmd_i.emit) begin
      chosen_r    <= hit ? INDEX_BITS'(di_r) : '0;
      found_r     <= hit;
      total_out_r <= total_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_index  = chosen_r;
  assign out_found         = found_r;
  assign out_total_fitness = total_out_r;

endmodule

@@ sv/roulette_wheel_selector_core.sv @@
// Channel  | Ports                                             | Transfer when
// ---------+---------------------------------------------------+-----------------------
// input    | in_kind, in_entry_index, in_fitness_value,        | start high, busy low
//          | in_random_fraction                                |
// result   | out_chosen_index, out_found, out_total_fitness    | out_valid high
// config   | cfg_genomes_in_use                                | cfg_valid, cfg_ready
//
// A write item is stored at its transfer and leaves the block free in the next cycle.
// A total or select item keeps busy high while it walks the N entries in use: one
// fitness table read per cycle through the single read port, then the last read lands,
// then the walk finishes; a select may end early.
// The result is registered and shows for exactly one cycle, while a new item is taken.
// Reset (rst_n low, synchronous) clears the controller, the running total and the
// count register (to 64); the fitness table holds no reset value.
// Results cannot be stalled; cfg_ready is always high.
module roulette_wheel_selector_core import rws_pkg::*; #(
  parameter int ENTRIES      = 64,
  parameter int FITNESS_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [KIND_BITS-1:0]    in_kind,
  input  logic [INDEX_BITS-1:0]   in_entry_index,
  input  logic [FITNESS_BITS-1:0] in_fitness_value,
  input  logic [RAND_BITS-1:0]    in_random_fraction,
  output logic                    out_valid,
  output logic [INDEX_BITS-1:0]   out_chosen_index,
  output logic                    out_found,
  output logic [TOTAL_BITS-1:0]   out_total_fitness,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_BITS-1:0]     cfg_genomes_in_use
);

  cmd_t    cmd;
  status_t status;

  // The count register is to be written only while the block is idle; the block
  // itself does not enforce this, so it is always ready to take a transfer.
  assign cfg_ready = 1'b1;

  // The controller sequences each item: writes pass straight through, while
  // totals and selections walk the table under its control.
  rws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_kind  (in_kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // The datapath holds the fitness table, the accumulator, the slice target
  // (random fraction times total, formed in one multiplier at the transfer)
  // and the registered result.
  rws_datapath #(
    .ENTRIES      (ENTRIES),
    .FITNESS_BITS (FITNESS_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_entry_index     (in_entry_index),
    .in_fitness_value   (in_fitness_value),
    .in_random_fraction (in_random_fraction),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_genomes_in_use (cfg_genomes_in_use),
    .out_valid          (out_valid),
    .out_chosen_index   (out_chosen_index),
    .out_found          (out_found),
    .out_total_fitness  (out_total_fitness)
  );

endmodule

@@ sv/rws_checker.sv @@
module rws_checker import rws_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [KIND_BITS-1:0]  in_kind,
  input logic                  out_valid,
  input logic [INDEX_BITS-1:0] out_chosen_index,
  input logic                  out_found
);

  // A result is shown only once the walk is over.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Two results never follow each other directly.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A miss reports entry zero.
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_chosen_index == '0))
    else $error("miss with non-zero index");

  // A selection transfer occupies the block.
  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_SELECT)) |=> busy)
    else $error("select did not start a walk");

  // A write transfer leaves the block free.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_WRITE)) |=> (!busy && !out_valid))
    else $error("write occupied the block");

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_chosen_index (out_chosen_index),
  .out_found        (out_found)
);
